/* src/cpc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_pkg: shared types, widths and helpers for the circle/polygon contact test.
// Holds the controller states, the datapath operation codes, the status
// bundle and the saturating and rounding helpers used by the datapath.
// ----------------------------------------------------------------------------
package cpc_pkg;

    localparam int COORD_W    = 32;
    localparam int TRIG_W     = 16;
    localparam int RADIUS_W   = 31;
    localparam int MUL_W      = 34;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int PROJ_W     = 34;
    localparam int ROOT_W     = 32;
    localparam int RADICAND_W = 63;
    localparam int DIV_NUM_W  = 61;
    localparam int DIV_DEN_W  = 32;
    localparam int QUOT_W     = 31;
    localparam int UNIT_SHIFT = 30;
    localparam int TRIG_SHIFT = 14;
    localparam int IN_DATA_W  = 256;
    localparam int OUT_DATA_W = 128;

    // Request kinds carried on the input side band.
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_VERTEX = 1'b1;

    typedef logic signed [PROD_W-1:0]  wide_t;
    typedef logic signed [COORD_W-1:0] coord_t;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [5:0] {
        OP_NONE,
        OP_START,
        OP_VERTEX,
        OP_XF0,
        OP_XF1,
        OP_XF2,
        OP_XF3,
        OP_XF4,
        OP_FIRST,
        OP_COMMIT,
        OP_SEG_NEXT,
        OP_SEG_CLOSE,
        OP_SQ0,
        OP_SQ1,
        OP_LEN_GO,
        OP_LEN_SAVE,
        OP_UX_GO,
        OP_UX_SAVE,
        OP_UY_GO,
        OP_UY_SAVE,
        OP_PR0,
        OP_PR1,
        OP_PR2,
        OP_FT0,
        OP_FT1,
        OP_FT2,
        OP_PICK,
        OP_DS0,
        OP_DS1,
        OP_DIST_GO,
        OP_DIST_SAVE,
        OP_NX_GO,
        OP_NX_SAVE,
        OP_NY_GO,
        OP_NY_SAVE,
        OP_EMIT
    } dp_op_t;

    // Controller states.
    typedef enum logic [5:0] {
        S_IDLE,
        S_XF0,
        S_XF1,
        S_XF2,
        S_XF3,
        S_XF4,
        S_FIRST,
        S_COMMIT,
        S_SEG,
        S_SQ0,
        S_SQ1,
        S_LEN_GO,
        S_LEN_WAIT,
        S_LEN_SAVE,
        S_UX_GO,
        S_UX_WAIT,
        S_UX_SAVE,
        S_UY_GO,
        S_UY_WAIT,
        S_UY_SAVE,
        S_PR0,
        S_PR1,
        S_PR2,
        S_FT0,
        S_FT1,
        S_FT2,
        S_PICK,
        S_DS0,
        S_DS1,
        S_DIST_GO,
        S_DIST_WAIT,
        S_DIST_SAVE,
        S_HIT_CHK,
        S_NX_GO,
        S_NX_WAIT,
        S_NX_SAVE,
        S_NY_GO,
        S_NY_WAIT,
        S_NY_SAVE,
        S_EMIT
    } cpc_state_t;

    // Status returned from the datapath to the controller.
    typedef struct packed {
        logic have_prev;
        logic hit;
        logic last;
        logic dist_lt_rad;
        logic sqrt_busy;
        logic div_busy;
        logic out_busy;
    } dp_status_t;

    // Saturate to the full signed 32-bit range.
    function automatic coord_t sat32(input wide_t v);
        coord_t r;
        if (v > wide_t'(64'sd2147483647))
        begin
            r = 32'sh7fffffff;
        end
        else if (v < -wide_t'(64'sd2147483648))
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    // Saturate a difference to the symmetric range.
    function automatic coord_t satd(input wide_t v);
        coord_t r;
        if (v > wide_t'(64'sd2147483647))
        begin
            r = 32'sh7fffffff;
        end
        else if (v < -wide_t'(64'sd2147483647))
        begin
            r = 32'sh80000001;
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    // Arithmetic right shift that rounds toward zero.
    function automatic wide_t shr_tz(input wide_t v, input int unsigned k);
        wide_t bias;
        bias = v[PROD_W-1] ? ((wide_t'(1) <<< k) - wide_t'(1)) : '0;
        return (v + bias) >>> k;
    endfunction

endpackage
`default_nettype wire

/* src/circle_polygon_contact.sv */
`timescale 1ns / 1ps
`default_nettype none
// A start request loads circle and pose. A vertex is transformed by the pose; the first
// one of a polygon is recorded, and a later one tests the edge from the previous vertex
// unless a hit is already held. Each tested edge takes two square roots and two
// divisions on the shared root and divide units; a hitting edge adds the two normal
// divisions. One request is in flight at a time. The result is registered once the
// output register is free, and the next request is taken while it waits.
// Reset (rst_n, asynchronous, active low) clears circle, pose, hit record and result.
// ----------------------------------------------------------------------------
// circle_polygon_contact: circle against convex polygon boundary test.
// Vertices stream in after a start request; the last one closes the polygon
// and returns the first contact found with normal, point and penetration.
// ----------------------------------------------------------------------------
module circle_polygon_contact
    import cpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // circle_x, circle_y, radius, pose_x, pose_y, pose_cos, pose_sin, vertex_x, vertex_y
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // command
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // normal_x, normal_y, contact_x, contact_y, penetration
    output logic [OUT_DATA_W-1:0] m_tdata,
    // colliding
    output logic                  m_tuser
);

    dp_op_t     op;
    dp_status_t status;

    // Sequencer.
    cpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .op       (op)
    );

    // Arithmetic and storage.
    cpc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_flag  (m_tuser),
        .out_data  (m_tdata)
    );

`ifndef ASSERT_OFF
    // The root unit is only started when idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_LEN_GO || op == OP_DIST_GO) |-> !status.sqrt_busy)
        else $error("root unit started while busy");

    // A result is only loaded when the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_EMIT) |-> !status.out_busy)
        else $error("result overwritten before it was taken");

    // New requests are taken only with both iterative units idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> (!status.sqrt_busy && !status.div_busy))
        else $error("request accepted while an iterative unit is busy");
`endif

endmodule
`default_nettype wire

/* src/cpc_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_sqrt: iterative floor square root.
// Produces one root bit per cycle from a 63-bit radicand.
// ----------------------------------------------------------------------------
module cpc_sqrt
    import cpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [RADICAND_W-1:0] radicand,
    output logic                  busy,
    output logic [ROOT_W-1:0]     root
);

    logic [2*ROOT_W-1:0]         rad_reg;
    logic [ROOT_W+1:0]           rem_reg;
    logic [ROOT_W-1:0]           root_reg;
    logic [$clog2(ROOT_W)-1:0]   cnt_reg;
    logic                        busy_reg;
    logic [ROOT_W+1:0]           rem_sh;
    logic [ROOT_W+1:0]           trial;
    logic                        ge;

    // One digit step: bring down two bits and try the next root bit.
    always_comb
    begin
        rem_sh = {rem_reg[ROOT_W-1:0], rad_reg[2*ROOT_W-1 -: 2]};
        trial  = {root_reg, 2'b01};
        ge     = (rem_sh >= trial);
    end

    // Iteration count and busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= ($clog2(ROOT_W))'(ROOT_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= {1'b0, radicand};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[2*ROOT_W-3:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

/* src/cpc_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_div: restoring unsigned divider.
// One quotient bit per cycle over a 61-bit dividend; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module cpc_div
    import cpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 busy,
    output logic [QUOT_W-1:0]    quot
);

    logic [DIV_NUM_W-1:0]          num_reg;
    logic [DIV_DEN_W-1:0]          den_reg;
    logic [DIV_DEN_W-1:0]          rem_reg;
    logic                          zero_reg;
    logic [$clog2(DIV_NUM_W)-1:0]  cnt_reg;
    logic                          busy_reg;
    logic [DIV_DEN_W:0]            rem_sh;
    logic [DIV_DEN_W:0]            rem_sub;
    logic                          ge;

    // Shift in one dividend bit and try a subtraction.
    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[DIV_NUM_W-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        ge      = (rem_sh >= {1'b0, den_reg});
    end

    // Iteration count and busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= ($clog2(DIV_NUM_W))'(DIV_NUM_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Quotient bits replace dividend bits from the bottom.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            zero_reg <= (den == '0);
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_NUM_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign quot = zero_reg ? '0 : num_reg[QUOT_W-1:0];

endmodule
`default_nettype wire

/* src/cpc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_datapath: registers, shared multiplier, root and divide units.
// Executes one controller operation per cycle and holds the result register.
// ----------------------------------------------------------------------------
module cpc_datapath
    import cpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_op_t                op,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic                  in_last,
    output dp_status_t            status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_flag,
    output logic [OUT_DATA_W-1:0] out_data
);

    // Circle and pose.
    coord_t                   cen_x_reg, cen_y_reg, pose_x_reg, pose_y_reg;
    logic [RADIUS_W-1:0]      rad_reg;
    logic signed [TRIG_W-1:0] cos_reg, sin_reg;
    // Vertex and polygon tracking.
    coord_t                   vx_reg, vy_reg, wx_reg, wy_reg;
    coord_t                   first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic                     last_reg, have_prev_reg, hit_reg;
    // Edge working values.
    coord_t                   ea_x_reg, ea_y_reg, eb_x_reg, eb_y_reg;
    coord_t                   sx_reg, sy_reg, cx_reg, cy_reg;
    coord_t                   ux_reg, uy_reg, fx_reg, fy_reg;
    coord_t                   ptx_reg, pty_reg, dx_reg, dy_reg;
    logic signed [PROJ_W-1:0] proj_reg;
    logic [ROOT_W-1:0]        len_reg, dist_reg;
    logic                     neg_reg;
    wide_t                    p_reg, t_reg;
    // Hit record.
    logic signed [TRIG_W-1:0] hit_nx_reg, hit_ny_reg;
    coord_t                   hit_cx_reg, hit_cy_reg;
    logic [RADIUS_W-1:0]      hit_pen_reg;
    // Result register.
    logic                     out_valid_reg, out_flag_reg;
    logic [OUT_DATA_W-1:0]    out_data_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    wide_t                    acc_sum;
    logic                     sqrt_start, sqrt_busy;
    logic [ROOT_W-1:0]        sqrt_root;
    logic                     div_start, div_busy;
    logic [DIV_NUM_W-1:0]     div_num;
    logic [DIV_DEN_W-1:0]     div_den;
    logic [QUOT_W-1:0]        div_quot;
    logic [QUOT_W-1:0]        abs_a;
    logic                     a_neg;
    coord_t                   seg_bx, seg_by, pick_x, pick_y;
    coord_t                   quot_signed;

    // Multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            OP_XF0:
            begin
                mul_a = MUL_W'(cos_reg);
                mul_b = MUL_W'(vx_reg);
            end
            OP_XF1:
            begin
                mul_a = MUL_W'(sin_reg);
                mul_b = MUL_W'(vy_reg);
            end
            OP_XF2:
            begin
                mul_a = MUL_W'(sin_reg);
                mul_b = MUL_W'(vx_reg);
            end
            OP_XF3:
            begin
                mul_a = MUL_W'(cos_reg);
                mul_b = MUL_W'(vy_reg);
            end
            OP_SQ0:
            begin
                mul_a = MUL_W'(sx_reg);
                mul_b = MUL_W'(sx_reg);
            end
            OP_SQ1:
            begin
                mul_a = MUL_W'(sy_reg);
                mul_b = MUL_W'(sy_reg);
            end
            OP_PR0:
            begin
                mul_a = MUL_W'(ux_reg);
                mul_b = MUL_W'(cx_reg);
            end
            OP_PR1:
            begin
                mul_a = MUL_W'(uy_reg);
                mul_b = MUL_W'(cy_reg);
            end
            OP_FT0:
            begin
                mul_a = MUL_W'(ux_reg);
                mul_b = proj_reg;
            end
            OP_FT1:
            begin
                mul_a = MUL_W'(uy_reg);
                mul_b = proj_reg;
            end
            OP_DS0:
            begin
                mul_a = MUL_W'(dx_reg);
                mul_b = MUL_W'(dx_reg);
            end
            OP_DS1:
            begin
                mul_a = MUL_W'(dy_reg);
                mul_b = MUL_W'(dy_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign acc_sum = t_reg + p_reg;

    // Divider set-up: the sign is kept apart and the magnitude divided.
    always_comb
    begin
        a_neg = 1'b0;
        abs_a = '0;
        div_num = '0;
        div_den = dist_reg;
        case (op)
            OP_UX_GO:
            begin
                a_neg   = sx_reg[COORD_W-1];
                abs_a   = a_neg ? QUOT_W'(-sx_reg) : QUOT_W'(sx_reg);
                div_num = {abs_a, {UNIT_SHIFT{1'b0}}};
                div_den = len_reg;
            end
            OP_UY_GO:
            begin
                a_neg   = sy_reg[COORD_W-1];
                abs_a   = a_neg ? QUOT_W'(-sy_reg) : QUOT_W'(sy_reg);
                div_num = {abs_a, {UNIT_SHIFT{1'b0}}};
                div_den = len_reg;
            end
            OP_NX_GO:
            begin
                a_neg   = dx_reg[COORD_W-1];
                abs_a   = a_neg ? QUOT_W'(-dx_reg) : QUOT_W'(dx_reg);
                div_num = DIV_NUM_W'({abs_a, {TRIG_SHIFT{1'b0}}});
            end
            OP_NY_GO:
            begin
                a_neg   = dy_reg[COORD_W-1];
                abs_a   = a_neg ? QUOT_W'(-dy_reg) : QUOT_W'(dy_reg);
                div_num = DIV_NUM_W'({abs_a, {TRIG_SHIFT{1'b0}}});
            end
            default:
            begin
                a_neg = 1'b0;
            end
        endcase
    end

    assign sqrt_start  = (op == OP_LEN_GO) || (op == OP_DIST_GO);
    assign div_start   = (op == OP_UX_GO) || (op == OP_UY_GO) ||
                         (op == OP_NX_GO) || (op == OP_NY_GO);
    assign quot_signed = neg_reg ? -coord_t'({1'b0, div_quot}) : coord_t'({1'b0, div_quot});

    // Edge end point and nearest point choice.
    assign seg_bx = (op == OP_SEG_CLOSE) ? first_x_reg : wx_reg;
    assign seg_by = (op == OP_SEG_CLOSE) ? first_y_reg : wy_reg;

    always_comb
    begin
        if (proj_reg[PROJ_W-1] || (proj_reg == '0))
        begin
            pick_x = ea_x_reg;
            pick_y = ea_y_reg;
        end
        else if (proj_reg >= $signed({2'b00, len_reg}))
        begin
            pick_x = eb_x_reg;
            pick_y = eb_y_reg;
        end
        else
        begin
            pick_x = fx_reg;
            pick_y = fy_reg;
        end
    end

    cpc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (acc_sum[RADICAND_W-1:0]),
        .busy     (sqrt_busy),
        .root     (sqrt_root)
    );

    cpc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // Architectural state with a defined reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cen_x_reg     <= '0;
            cen_y_reg     <= '0;
            rad_reg       <= '0;
            pose_x_reg    <= '0;
            pose_y_reg    <= '0;
            cos_reg       <= '0;
            sin_reg       <= '0;
            have_prev_reg <= 1'b0;
            hit_reg       <= 1'b0;
            hit_nx_reg    <= '0;
            hit_ny_reg    <= '0;
            hit_cx_reg    <= '0;
            hit_cy_reg    <= '0;
            hit_pen_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_flag_reg  <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (op)
                OP_START:
                begin
                    cen_x_reg     <= $signed(in_data[31:0]);
                    cen_y_reg     <= $signed(in_data[63:32]);
                    rad_reg       <= in_data[94:64];
                    pose_x_reg    <= $signed(in_data[126:95]);
                    pose_y_reg    <= $signed(in_data[158:127]);
                    cos_reg       <= $signed(in_data[174:159]);
                    sin_reg       <= $signed(in_data[190:175]);
                    have_prev_reg <= 1'b0;
                    hit_reg       <= 1'b0;
                    hit_nx_reg    <= '0;
                    hit_ny_reg    <= '0;
                    hit_cx_reg    <= '0;
                    hit_cy_reg    <= '0;
                    hit_pen_reg   <= '0;
                end
                OP_FIRST:
                begin
                    have_prev_reg <= 1'b1;
                end
                OP_NX_SAVE:
                begin
                    hit_nx_reg <= quot_signed[TRIG_W-1:0];
                end
                OP_NY_SAVE:
                begin
                    hit_ny_reg  <= quot_signed[TRIG_W-1:0];
                    hit_cx_reg  <= ptx_reg;
                    hit_cy_reg  <= pty_reg;
                    hit_pen_reg <= rad_reg - dist_reg[RADIUS_W-1:0];
                    hit_reg     <= 1'b1;
                end
                OP_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                    out_flag_reg  <= hit_reg;
                    out_data_reg  <= {1'b0, hit_pen_reg, hit_cy_reg, hit_cx_reg,
                                      hit_ny_reg, hit_nx_reg};
                    have_prev_reg <= 1'b0;
                    hit_reg       <= 1'b0;
                    hit_nx_reg    <= '0;
                    hit_ny_reg    <= '0;
                    hit_cx_reg    <= '0;
                    hit_cy_reg    <= '0;
                    hit_pen_reg   <= '0;
                end
                default:
                begin
                    hit_reg <= hit_reg;
                end
            endcase
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        p_reg <= mul_a * mul_b;
        case (op)
            OP_VERTEX:
            begin
                vx_reg   <= $signed(in_data[222:191]);
                vy_reg   <= $signed(in_data[254:223]);
                last_reg <= in_last;
            end
            OP_XF1, OP_XF3, OP_SQ1, OP_PR1, OP_DS1:
            begin
                t_reg <= p_reg;
            end
            OP_XF2:
            begin
                wx_reg <= sat32(wide_t'(pose_x_reg) + shr_tz(t_reg - p_reg, TRIG_SHIFT));
            end
            OP_XF4:
            begin
                wy_reg <= sat32(wide_t'(pose_y_reg) + shr_tz(acc_sum, TRIG_SHIFT));
            end
            OP_FIRST:
            begin
                first_x_reg <= wx_reg;
                first_y_reg <= wy_reg;
            end
            OP_COMMIT:
            begin
                prev_x_reg <= wx_reg;
                prev_y_reg <= wy_reg;
            end
            OP_SEG_NEXT, OP_SEG_CLOSE:
            begin
                ea_x_reg <= prev_x_reg;
                ea_y_reg <= prev_y_reg;
                eb_x_reg <= seg_bx;
                eb_y_reg <= seg_by;
                sx_reg   <= satd(wide_t'(seg_bx) - wide_t'(prev_x_reg));
                sy_reg   <= satd(wide_t'(seg_by) - wide_t'(prev_y_reg));
                cx_reg   <= satd(wide_t'(cen_x_reg) - wide_t'(prev_x_reg));
                cy_reg   <= satd(wide_t'(cen_y_reg) - wide_t'(prev_y_reg));
            end
            OP_LEN_SAVE:
            begin
                len_reg <= sqrt_root;
            end
            OP_UX_GO, OP_UY_GO, OP_NX_GO, OP_NY_GO:
            begin
                neg_reg <= a_neg;
            end
            OP_UX_SAVE:
            begin
                ux_reg <= quot_signed;
            end
            OP_UY_SAVE:
            begin
                uy_reg <= quot_signed;
            end
            OP_PR2:
            begin
                proj_reg <= PROJ_W'(shr_tz(acc_sum, UNIT_SHIFT));
            end
            OP_FT1:
            begin
                fx_reg <= sat32(wide_t'(ea_x_reg) + shr_tz(p_reg, UNIT_SHIFT));
            end
            OP_FT2:
            begin
                fy_reg <= sat32(wide_t'(ea_y_reg) + shr_tz(p_reg, UNIT_SHIFT));
            end
            OP_PICK:
            begin
                ptx_reg <= pick_x;
                pty_reg <= pick_y;
                dx_reg  <= satd(wide_t'(cen_x_reg) - wide_t'(pick_x));
                dy_reg  <= satd(wide_t'(cen_y_reg) - wide_t'(pick_y));
            end
            OP_DIST_SAVE:
            begin
                dist_reg <= sqrt_root;
            end
            default:
            begin
                t_reg <= t_reg;
            end
        endcase
    end

    // Status for the controller.
    always_comb
    begin
        status.have_prev   = have_prev_reg;
        status.hit         = hit_reg;
        status.last        = last_reg;
        status.dist_lt_rad = (dist_reg < ROOT_W'(rad_reg));
        status.sqrt_busy   = sqrt_busy;
        status.div_busy    = div_busy;
        status.out_busy    = out_valid_reg && !out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_flag  = out_flag_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

/* src/cpc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_ctrl: sequencing state machine.
// Takes start requests in idle and steps each vertex through transform, edge test and result hand-off.
// ----------------------------------------------------------------------------
module cpc_ctrl
    import cpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_kind,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_op_t     op
);

    cpc_state_t state_reg, state_next;
    logic       close_reg, close_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            close_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            close_reg <= close_next;
        end
    end

    // Next state and datapath operation.
    always_comb
    begin
        state_next = state_reg;
        close_next = close_reg;
        op         = OP_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_kind == CMD_VERTEX)
                    begin
                        op         = OP_VERTEX;
                        state_next = S_XF0;
                    end
                    else
                    begin
                        op = OP_START;
                    end
                end
            end
            S_XF0:
            begin
                op         = OP_XF0;
                state_next = S_XF1;
            end
            S_XF1:
            begin
                op         = OP_XF1;
                state_next = S_XF2;
            end
            S_XF2:
            begin
                op         = OP_XF2;
                state_next = S_XF3;
            end
            S_XF3:
            begin
                op         = OP_XF3;
                state_next = S_XF4;
            end
            S_XF4:
            begin
                op = OP_XF4;
                if (!status.have_prev)
                begin
                    state_next = S_FIRST;
                end
                else if (!status.hit)
                begin
                    close_next = 1'b0;
                    state_next = S_SEG;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_FIRST:
            begin
                op         = OP_FIRST;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                op = OP_COMMIT;
                if (!status.last)
                begin
                    state_next = S_IDLE;
                end
                else if (status.hit)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    close_next = 1'b1;
                    state_next = S_SEG;
                end
            end
            S_SEG:
            begin
                op         = close_reg ? OP_SEG_CLOSE : OP_SEG_NEXT;
                state_next = S_SQ0;
            end
            S_SQ0:
            begin
                op         = OP_SQ0;
                state_next = S_SQ1;
            end
            S_SQ1:
            begin
                op         = OP_SQ1;
                state_next = S_LEN_GO;
            end
            S_LEN_GO:
            begin
                op         = OP_LEN_GO;
                state_next = S_LEN_WAIT;
            end
            S_LEN_WAIT:
            begin
                if (!status.sqrt_busy)
                begin
                    state_next = S_LEN_SAVE;
                end
            end
            S_LEN_SAVE:
            begin
                op         = OP_LEN_SAVE;
                state_next = S_UX_GO;
            end
            S_UX_GO:
            begin
                op         = OP_UX_GO;
                state_next = S_UX_WAIT;
            end
            S_UX_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_UX_SAVE;
                end
            end
            S_UX_SAVE:
            begin
                op         = OP_UX_SAVE;
                state_next = S_UY_GO;
            end
            S_UY_GO:
            begin
                op         = OP_UY_GO;
                state_next = S_UY_WAIT;
            end
            S_UY_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_UY_SAVE;
                end
            end
            S_UY_SAVE:
            begin
                op         = OP_UY_SAVE;
                state_next = S_PR0;
            end
            S_PR0:
            begin
                op         = OP_PR0;
                state_next = S_PR1;
            end
            S_PR1:
            begin
                op         = OP_PR1;
                state_next = S_PR2;
            end
            S_PR2:
            begin
                op         = OP_PR2;
                state_next = S_FT0;
            end
            S_FT0:
            begin
                op         = OP_FT0;
                state_next = S_FT1;
            end
            S_FT1:
            begin
                op         = OP_FT1;
                state_next = S_FT2;
            end
            S_FT2:
            begin
                op         = OP_FT2;
                state_next = S_PICK;
            end
            S_PICK:
            begin
                op         = OP_PICK;
                state_next = S_DS0;
            end
            S_DS0:
            begin
                op         = OP_DS0;
                state_next = S_DS1;
            end
            S_DS1:
            begin
                op         = OP_DS1;
                state_next = S_DIST_GO;
            end
            S_DIST_GO:
            begin
                op         = OP_DIST_GO;
                state_next = S_DIST_WAIT;
            end
            S_DIST_WAIT:
            begin
                if (!status.sqrt_busy)
                begin
                    state_next = S_DIST_SAVE;
                end
            end
            S_DIST_SAVE:
            begin
                op         = OP_DIST_SAVE;
                state_next = S_HIT_CHK;
            end
            S_HIT_CHK:
            begin
                if (status.dist_lt_rad)
                begin
                    state_next = S_NX_GO;
                end
                else
                begin
                    state_next = close_reg ? S_EMIT : S_COMMIT;
                end
            end
            S_NX_GO:
            begin
                op         = OP_NX_GO;
                state_next = S_NX_WAIT;
            end
            S_NX_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_NX_SAVE;
                end
            end
            S_NX_SAVE:
            begin
                op         = OP_NX_SAVE;
                state_next = S_NY_GO;
            end
            S_NY_GO:
            begin
                op         = OP_NY_GO;
                state_next = S_NY_WAIT;
            end
            S_NY_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_NY_SAVE;
                end
            end
            S_NY_SAVE:
            begin
                op         = OP_NY_SAVE;
                state_next = close_reg ? S_EMIT : S_COMMIT;
            end
            S_EMIT:
            begin
                if (!status.out_busy)
                begin
                    op         = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
